### src/hsmseq_pkg.sv
// Shared types, constants and the half-step coil table for the motor sequencer.
`timescale 1ns / 1ps

package hsmseq_pkg;

	localparam int unsigned PHASE_COUNT = 8;
	localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);

	localparam logic [15:0] RESET_STEPS_PER_REV = 16'd400;
	localparam logic [31:0] RESET_STEP_PERIOD   = 32'd5000;
	localparam logic [31:0] ELAPSED_MAX         = 32'hFFFF_FFFF;

	// Request kinds
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_MOVE = 1'b1
	} req_kind_t;

	// Configuration register indexes
	typedef enum logic {
		REG_STEPS_PER_REV = 1'b0,
		REG_STEP_PERIOD   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] move_count;
	} req_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic [15:0] position;
		logic [15:0] remaining;
		logic        stepped;
		logic        busy_res;
	} rsp_t;

	// Eight-phase half-step pattern, bit3 = wire1 .. bit0 = wire4
	function automatic logic [3:0] phase_pattern(input logic [PHASE_W-1:0] phase);
		logic [3:0] pat;
		case (phase)
			3'd0:    pat = 4'h8;
			3'd1:    pat = 4'hA;
			3'd2:    pat = 4'h2;
			3'd3:    pat = 4'h6;
			3'd4:    pat = 4'h4;
			3'd5:    pat = 4'h5;
			3'd6:    pat = 4'h1;
			3'd7:    pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

### src/half_step_motor_sequencer_core.sv
// Top level of the half-step stepper motor sequencer.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  req     | in        | req_valid / req_stall  | req_type, move_count (tick / move)
//  rsp     | out       | rsp_valid / rsp_stall  | coils, position, remaining, stepped,
//          |           |                        | busy_res (one per request)
//  cfg     | in        | cfg_wr_en              | cfg_index, cfg_wdata (write only)
//
//  Each request passes from acceptance into the input register, then through
//  the step logic into the result register.
//  A new request is accepted every cycle while req_stall is low; the rate is
//  set by the single pass of compare, increment and table lookup between the two registers.
//  Reset clears the motor state to position 0, no steps pending, reverse
//  direction, coils off, and loads the default geometry and step period.
//  A stall on rsp holds the result register; the input register then fills
//  and req_stall rises only when both are occupied.

module half_step_motor_sequencer_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               req_valid,
	output logic               req_stall,
	input  hsmseq_pkg::req_t   req_data,

	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hsmseq_pkg::rsp_t   rsp_data,

	input  logic               cfg_wr_en,
	input  hsmseq_pkg::cfg_reg_t cfg_index,
	input  logic [31:0]        cfg_wdata
);

	// Configuration registers
	logic [15:0] spr_q;
	logic [31:0] period_q;

	// Motor state
	logic [15:0] pos_q;
	logic [15:0] rem_q;
	logic        fwd_q;
	logic [31:0] elapsed_q;
	logic [3:0]  coil_q;

	// Input register
	logic             valid_s1;
	hsmseq_pkg::req_t req_s1;

	// Result register
	logic             rsp_valid_q;
	hsmseq_pkg::rsp_t rsp_q;

	logic adv;
	logic req_accept;

	// Next-state values for the transaction in the input register
	logic [15:0] pos_d;
	logic [15:0] rem_d;
	logic        fwd_d;
	logic [31:0] elapsed_d;
	logic [3:0]  coil_d;
	logic        stepped_d;
	logic [31:0] elapsed_inc;
	logic [15:0] pos_step;
	logic [15:0] move_mag;

	assign adv        = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = valid_s1 && !adv;
	assign req_accept = req_valid && !req_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Configuration writes; an index outside the list is dropped by the enum decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q    <= hsmseq_pkg::RESET_STEPS_PER_REV;
			period_q <= hsmseq_pkg::RESET_STEP_PERIOD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hsmseq_pkg::REG_STEPS_PER_REV: spr_q    <= cfg_wdata[15:0];
				hsmseq_pkg::REG_STEP_PERIOD:   period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register: load on accept, drop once passed into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1 <= req_data;
		end
	end

	// Position after one step, with wrap in either direction.
	// A zero revolution length pins the position at zero.
	always_comb begin
		if (spr_q == 16'd0) begin
			pos_step = 16'd0;
		end else if (fwd_q) begin
			if (({1'b0, pos_q} + 17'd1) >= {1'b0, spr_q}) begin
				pos_step = 16'd0;
			end else begin
				pos_step = pos_q + 16'd1;
			end
		end else if (pos_q == 16'd0) begin
			pos_step = spr_q - 16'd1;
		end else begin
			pos_step = pos_q - 16'd1;
		end
	end

	// Saturating tick count
	assign elapsed_inc = (elapsed_q == hsmseq_pkg::ELAPSED_MAX) ? elapsed_q
	                                                            : elapsed_q + 32'd1;

	// Magnitude of the signed move count; the most negative count gives 32768
	assign move_mag = req_s1.move_count[15] ? (16'd0 - req_s1.move_count)
	                                        : req_s1.move_count;

	always_comb begin
		pos_d     = pos_q;
		rem_d     = rem_q;
		fwd_d     = fwd_q;
		elapsed_d = elapsed_q;
		coil_d    = coil_q;
		stepped_d = 1'b0;
		case (hsmseq_pkg::req_kind_t'(req_s1.req_type))
			hsmseq_pkg::REQ_MOVE: begin
				// Replace any pending move; a zero count keeps the direction
				rem_d = move_mag;
				if (req_s1.move_count[15]) begin
					fwd_d = 1'b0;
				end else if (req_s1.move_count != 16'sd0) begin
					fwd_d = 1'b1;
				end
			end
			hsmseq_pkg::REQ_TICK: begin
				elapsed_d = elapsed_inc;
				if (rem_q != 16'd0 && elapsed_inc >= period_q) begin
					elapsed_d = 32'd0;
					pos_d     = pos_step;
					rem_d     = rem_q - 16'd1;
					coil_d    = hsmseq_pkg::phase_pattern(pos_step[hsmseq_pkg::PHASE_W-1:0]);
					stepped_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Commit motor state as the transaction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 16'd0;
			rem_q     <= 16'd0;
			fwd_q     <= 1'b0;
			elapsed_q <= 32'd0;
			coil_q    <= 4'd0;
		end else if (adv) begin
			pos_q     <= pos_d;
			rem_q     <= rem_d;
			fwd_q     <= fwd_d;
			elapsed_q <= elapsed_d;
			coil_q    <= coil_d;
		end
	end

	// Result register: hold under stall, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.coils     <= coil_d;
			rsp_q.position  <= pos_d;
			rsp_q.remaining <= rem_d;
			rsp_q.stepped   <= stepped_d;
			rsp_q.busy_res  <= (rem_d != 16'd0);
		end
	end

	// A stepping result always shows the coil pattern of its position
	a_step_coils: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.stepped |->
			rsp_data.coils ==
			hsmseq_pkg::phase_pattern(rsp_data.position[hsmseq_pkg::PHASE_W-1:0]))
		else $error("coil pattern does not match stepped position");

	// Busy flag tracks the remaining count
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.busy_res == (rsp_data.remaining != 16'd0))
		else $error("busy_res disagrees with remaining");

	// An accepted request lands in the input register
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> valid_s1)
		else $error("accepted request lost before the input register");

	// Stall upstream only when both registers are full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_q && rsp_stall)
		else $error("request stalled without a full pipeline");

	// A move result never reports a step
	a_move_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.req_type == hsmseq_pkg::REQ_MOVE |=> !rsp_data.stepped)
		else $error("move command reported a step");

endmodule

### verif/testbench.sv
// Self-checking testbench for the half-step stepper motor sequencer core.
`timescale 1ns / 1ps

module testbench;

	// Half-step coil patterns, phase 0 in the low nibble
	localparam logic [31:0] COIL_SEQ = {4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic                 req_valid = 1'b0;
	logic                 req_stall;
	hsmseq_pkg::req_t     req_data = '0;

	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	hsmseq_pkg::rsp_t     rsp_data;

	logic                 cfg_wr_en = 1'b0;
	hsmseq_pkg::cfg_reg_t cfg_index = hsmseq_pkg::REG_STEPS_PER_REV;
	logic [31:0]          cfg_wdata = '0;

	half_step_motor_sequencer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the motor state and geometry, starting from reset values
	logic [15:0] spr_q     = hsmseq_pkg::RESET_STEPS_PER_REV;
	logic [31:0] period_q  = hsmseq_pkg::RESET_STEP_PERIOD;
	logic [15:0] pos_q     = '0;
	logic [15:0] rem_q     = '0;
	logic        fwd_q     = 1'b0;
	logic [31:0] elapsed_q = '0;
	logic [3:0]  coil_q    = '0;

	hsmseq_pkg::req_t req_backlog[$];   // requests waiting to be driven
	hsmseq_pkg::rsp_t status_due[$];    // predicted motor status, oldest first
	hsmseq_pkg::rsp_t want_rsp;

	int n_issued  = 0;
	int n_taken   = 0;
	int n_checked = 0;
	int err_count = 0;

	logic req_fire = 1'b0;  // request transaction completed at the last rising edge
	int   burst_left = 0;
	int   gap_left = 0;
	int   stall_mode = 0;
	int   mode_left = 0;
	int   stall_tick = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one request to the mirrored state and return the status it yields
	function automatic hsmseq_pkg::rsp_t motor_step(hsmseq_pkg::req_t item);
		hsmseq_pkg::rsp_t r;
		logic took;
		took = 1'b0;
		if (item.req_type == hsmseq_pkg::REQ_MOVE) begin
			// Load the magnitude; a zero count cancels the move but keeps direction
			if (item.move_count[15]) begin
				rem_q = 16'h0000 - item.move_count;
				fwd_q = 1'b0;
			end else begin
				rem_q = item.move_count;
				if (item.move_count != 16'sd0)
					fwd_q = 1'b1;
			end
		end else begin
			if (elapsed_q != hsmseq_pkg::ELAPSED_MAX)
				elapsed_q = elapsed_q + 32'd1;
			if (rem_q != 16'd0 && elapsed_q >= period_q) begin
				elapsed_q = '0;
				if (spr_q == 16'd0)
					pos_q = '0;
				else if (fwd_q)
					pos_q = ({16'd0, pos_q} + 32'd1 >= {16'd0, spr_q}) ? 16'd0
						: pos_q + 16'd1;
				else
					pos_q = (pos_q == 16'd0) ? spr_q - 16'd1 : pos_q - 16'd1;
				rem_q  = rem_q - 16'd1;
				coil_q = COIL_SEQ[pos_q[hsmseq_pkg::PHASE_W-1:0]*4 +: 4];
				took   = 1'b1;
			end
		end
		r.coils     = coil_q;
		r.position  = pos_q;
		r.remaining = rem_q;
		r.stepped   = took;
		r.busy_res  = (rem_q != 16'd0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	task automatic queue_req(input hsmseq_pkg::req_kind_t kind, input logic [15:0] cnt);
		hsmseq_pkg::req_t item;
		item.req_type   = kind;
		item.move_count = cnt;
		req_backlog.push_back(item);
		n_issued++;
	endtask

	// Wait until every queued request has been accepted and answered, then let the
	// two-stage pipeline settle before touching the registers
	task automatic drain();
		while (n_taken != n_issued || n_checked != n_taken)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input hsmseq_pkg::cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_geometry(input logic [15:0] spr, input logic [31:0] period);
		drain();
		write_cfg(hsmseq_pkg::REG_STEPS_PER_REV, {16'd0, spr});
		write_cfg(hsmseq_pkg::REG_STEP_PERIOD, period);
	endtask

	// Random phase: mostly ticks, moves biased to short counts so steps finish,
	// with extreme and fully random counts mixed in
	task automatic random_phase(input int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 72)
				queue_req(hsmseq_pkg::REQ_TICK, 16'($urandom));
			else if (sel < 90)
				queue_req(hsmseq_pkg::REQ_MOVE, 16'($urandom_range(0, 40) - 20));
			else if (sel < 95) begin
				case ($urandom_range(0, 3))
					0:       queue_req(hsmseq_pkg::REQ_MOVE, 16'h8000);
					1:       queue_req(hsmseq_pkg::REQ_MOVE, 16'h7FFF);
					2:       queue_req(hsmseq_pkg::REQ_MOVE, 16'h0000);
					default: queue_req(hsmseq_pkg::REQ_MOVE, 16'hFFFF);
				endcase
			end else
				queue_req(hsmseq_pkg::REQ_MOVE, 16'($urandom));
		end
	endtask

	// Driver: present the next request once the current one is taken, in bursts
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req_data  <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					// Start a new burst; a quarter of them follow with no gap
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else
					burst_left--;
			end else
				req_valid <= 1'b0;
		end
	end

	// Receiver: switch among four stall patterns at random
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 150);
		end
		mode_left--;
		stall_tick++;
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 9) < 3);
			2:       rsp_stall <= (stall_tick % 3 == 0);
			default: rsp_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Monitor: mirror register writes, predict accepted requests, check results
	always @(posedge clk) begin
		req_fire <= arst_n && req_valid && !req_stall;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					hsmseq_pkg::REG_STEPS_PER_REV: spr_q    = cfg_wdata[15:0];
					hsmseq_pkg::REG_STEP_PERIOD:   period_q = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				status_due.push_back(motor_step(req_data));
				n_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				n_checked++;
				if (status_due.size() == 0)
					report_mismatch("result transaction with no request outstanding");
				else begin
					want_rsp = status_due.pop_front();
					if (rsp_data.coils !== want_rsp.coils)
						report_mismatch($sformatf("coils got %h want %h",
							rsp_data.coils, want_rsp.coils));
					if (rsp_data.position !== want_rsp.position)
						report_mismatch($sformatf("position got %0d want %0d",
							rsp_data.position, want_rsp.position));
					if (rsp_data.remaining !== want_rsp.remaining)
						report_mismatch($sformatf("remaining got %0d want %0d",
							rsp_data.remaining, want_rsp.remaining));
					if (rsp_data.stepped !== want_rsp.stepped)
						report_mismatch($sformatf("stepped got %b want %b",
							rsp_data.stepped, want_rsp.stepped));
					if (rsp_data.busy_res !== want_rsp.busy_res)
						report_mismatch($sformatf("busy_res got %b want %b",
							rsp_data.busy_res, want_rsp.busy_res));
				end
			end
		end
	end

	// Hard stop in case the pipeline hangs
	initial begin
		#(5_000_000);
		$display("** half_step_motor_sequencer_core: FAILED **");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: idle status, then a reverse move that cannot step yet
		queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'hFFFE);
		queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);

		// Short revolution, step on every tick: forward run, backward wrap through 0
		set_geometry(16'd8, 32'd1);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'd3);
		repeat (4) queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'hFFFB);
		repeat (5) queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);
		// Zero count cancels a pending move without changing direction
		queue_req(hsmseq_pkg::REQ_MOVE, 16'hFFFC);
		queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'h0000);
		queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);
		// Largest counts in each direction
		queue_req(hsmseq_pkg::REQ_MOVE, 16'h7FFF);
		queue_req(hsmseq_pkg::REQ_TICK, 16'hFFFF);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'h8000);
		queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);

		// Out-of-range geometry: zero revolution holds position, zero period steps always
		set_geometry(16'd0, 32'd0);
		queue_req(hsmseq_pkg::REQ_MOVE, 16'd2);
		repeat (2) queue_req(hsmseq_pkg::REQ_TICK, 16'h0000);

		// Extreme settings, then a lowered revolution below the current position
		set_geometry(16'hFFFF, 32'd1);
		random_phase(120);
		set_geometry(16'd5, 32'd2);
		random_phase(100);
		set_geometry(16'd1, 32'd1);
		random_phase(80);
		set_geometry(16'd0, 32'd0);
		random_phase(60);
		set_geometry(16'hFFFF, 32'hFFFF_FFFF);
		random_phase(40);

		// Random geometry, mostly short revolutions and short periods
		for (int p = 0; p < 5; p++) begin
			set_geometry(($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 24)), 32'($urandom_range(0, 6)));
			random_phase(80);
		end

		drain();
		repeat (10) @(posedge clk);
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", status_due.size()));
		if (err_count == 0)
			$display("** half_step_motor_sequencer_core: PASSED **");
		else
			$display("** half_step_motor_sequencer_core: FAILED **");
		$finish;
	end

endmodule
